>>> rtl/core/wfp_pkg.sv
// Shared types and constants for the weight frame parser.
// Used by wfp_digit_cell and weight_frame_parser; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wfp_pkg;

  localparam int FRAME_LENGTH = 22;
  localparam int FIELD_OFFSET = 9;
  localparam int FIELD_CHARS  = 8;
  localparam int CR_POS       = 20;
  localparam int LF_POS       = 21;

  localparam int COUNT_W = 5;
  localparam int VALUE_W = 28;
  localparam int EXP_W   = 5;

  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNSTABLE = 3'd1,
    ST_OVERLOAD = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_NOSIGNAL = 3'd4
  } status_t;

  typedef struct packed {
    status_t                         status;
    logic [FIELD_CHARS-1:0][7:0]     chars;
    logic [VALUE_W-1:0]              value;
    logic                            neg;
    logic [EXP_W-1:0]                expo;
  } dec_t;

endpackage

`default_nettype wire

>>> rtl/core/wfp_byte_cell.sv
// One byte cell of the receive window shift line.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module wfp_byte_cell (
  input  wire logic       clk,
  input  wire logic       shift_en,
  input  wire logic [7:0] byte_in,
  output logic      [7:0] byte_out
);

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;

endmodule

`default_nettype wire

>>> rtl/core/wfp_digit_cell.sv
// One stage of the weight decode chain: folds one field character into the
// running value, sign and decimal exponent. Depends on wfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wfp_digit_cell #(
  parameter int IDX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire wfp_pkg::dec_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output wfp_pkg::dec_t      out_data
);

  localparam int LAST_IDX = wfp_pkg::FIELD_CHARS - 1;

  logic          valid_r;
  wfp_pkg::dec_t data_r;
  wfp_pkg::dec_t data_nxt;
  logic [7:0]    ch;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    ch       = in_data.chars[IDX];
    data_nxt = in_data;
    if (ch == wfp_pkg::CH_MINUS) begin
      data_nxt.neg = ~in_data.neg;
    end else if (ch == wfp_pkg::CH_POINT) begin
      data_nxt.expo = in_data.expo + wfp_pkg::EXP_W'(LAST_IDX - IDX);
    end else if (ch >= wfp_pkg::CH_ZERO && ch <= wfp_pkg::CH_NINE) begin
      data_nxt.value = (in_data.value << 3) + (in_data.value << 1)
                     + wfp_pkg::VALUE_W'(ch - wfp_pkg::CH_ZERO);
    end
    if (IDX == LAST_IDX && data_nxt.neg) begin
      data_nxt.value = wfp_pkg::VALUE_W'(0) - data_nxt.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

>>> rtl/core/weight_frame_parser.sv
// Weight frame parser: a result passes through the eight digit cells in order to the output;
// the first digit cell loads at the transfer that causes it, each later cell from the one before.
// One input transfer per cycle when not stalled.
// Window checks and frame match run in the cycle of the input transfer.
// Synchronous active-low reset clears the burst counter, burst flag and cell valids.
// Depends on wfp_pkg, wfp_byte_cell and wfp_digit_cell.
`timescale 1ns / 1ps
`default_nettype none

module weight_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // end_of_read
  input  wire logic        in_tuser,   // [0] empty_read
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // [27:0] weight_value, [32:28] decimal_exponent
  output logic      [2:0]  out_tuser   // [2:0] status
);

  localparam int FL = wfp_pkg::FRAME_LENGTH;
  localparam int NC = wfp_pkg::FIELD_CHARS;

  logic [7:0] win_q   [FL];
  logic [7:0] win_nxt [FL];
  logic       shift_en;

  logic [wfp_pkg::COUNT_W-1:0] count_r, count_nxt, count_inc;
  logic                        done_r, done_nxt;
  logic                        accept, emit, full;
  wfp_pkg::status_t            st;

  logic          stage_valid [NC+1];
  logic          stage_ready [NC+1];
  wfp_pkg::dec_t stage_data  [NC+1];

  for (genvar i = 0; i < FL; i++) begin : g_win
    if (i == FL - 1) begin : g_tail
      assign win_nxt[i] = in_tdata;
    end else begin : g_body
      assign win_nxt[i] = win_q[i+1];
    end
    wfp_byte_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .byte_in  (win_nxt[i]),
      .byte_out (win_q[i])
    );
  end

  assign accept    = in_tvalid && in_tready;
  assign count_inc = (count_r < wfp_pkg::COUNT_W'(FL)) ? count_r + 1'b1 : count_r;
  assign full      = (count_inc >= wfp_pkg::COUNT_W'(FL));

  always_comb begin
    count_nxt = count_r;
    done_nxt  = done_r;
    emit      = 1'b0;
    shift_en  = 1'b0;
    st        = wfp_pkg::ST_TIMEOUT;
    if (accept) begin
      if (in_tuser) begin
        count_nxt = '0;
        done_nxt  = 1'b0;
        emit      = 1'b1;
        st        = wfp_pkg::ST_NOSIGNAL;
      end else begin
        if (!done_r) begin
          shift_en  = 1'b1;
          count_nxt = count_inc;
          if (full) begin
            if (win_nxt[0] == wfp_pkg::CH_U && win_nxt[1] == wfp_pkg::CH_S) begin
              emit = 1'b1;
              st   = wfp_pkg::ST_UNSTABLE;
            end else if (win_nxt[0] == wfp_pkg::CH_O && win_nxt[1] == wfp_pkg::CH_L) begin
              emit = 1'b1;
              st   = wfp_pkg::ST_OVERLOAD;
            end else if (win_nxt[0] == wfp_pkg::CH_S && win_nxt[1] == wfp_pkg::CH_T &&
                         win_nxt[wfp_pkg::CR_POS] == wfp_pkg::CH_CR &&
                         win_nxt[wfp_pkg::LF_POS] == wfp_pkg::CH_LF) begin
              emit = 1'b1;
              st   = wfp_pkg::ST_OK;
            end
          end
          done_nxt = emit;
          if (in_tlast && !emit) begin
            emit = 1'b1;
            st   = wfp_pkg::ST_TIMEOUT;
          end
        end
        if (in_tlast) begin
          count_nxt = '0;
          done_nxt  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      done_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      done_r  <= done_nxt;
    end
  end

  always_comb begin
    stage_data[0].status = st;
    stage_data[0].value  = '0;
    stage_data[0].neg    = 1'b0;
    stage_data[0].expo   = '0;
    for (int k = 0; k < NC; k++) begin
      stage_data[0].chars[k] = (st == wfp_pkg::ST_OK) ?
                               win_nxt[wfp_pkg::FIELD_OFFSET + k] : wfp_pkg::CH_SPACE;
    end
  end

  assign stage_valid[0]  = emit;
  assign in_tready       = stage_ready[0];
  assign stage_ready[NC] = out_tready;

  for (genvar k = 0; k < NC; k++) begin : g_dec
    wfp_digit_cell #(
      .IDX (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stage_valid[k]),
      .in_ready  (stage_ready[k]),
      .in_data   (stage_data[k]),
      .out_valid (stage_valid[k+1]),
      .out_ready (stage_ready[k+1]),
      .out_data  (stage_data[k+1])
    );
  end

  assign out_tvalid = stage_valid[NC];
  assign out_tuser  = stage_data[NC].status;
  assign out_tdata  = {7'd0, stage_data[NC].expo, stage_data[NC].value};

endmodule

`default_nettype wire
